[rtl/marker_delimited_frame_receiver_top_assert.svh]
// Assertion macros for the marker-delimited frame receiver.
// Used by marker_delimited_frame_receiver_top.sv; needs ports named clock and reset.
`ifndef MARKER_DELIMITED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define MARKER_DELIMITED_FRAME_RECEIVER_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define MDFR_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define MDFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// A condition that forces another in the same cycle.
`define MDFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/mdfr_pkg.sv]
// Shared codes, characters and the marker matcher of the frame receiver.
// No dependencies; used by marker_delimited_frame_receiver_top.sv.
`timescale 1ns / 1ps
`default_nettype none

package mdfr_pkg;

   // Operation codes carried in the input tuser.
   localparam logic [1:0] OP_RX_BYTE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_REARM   = 2'd2;

   // Event codes carried in the result tuser.
   localparam logic [1:0] EVT_READ_DATA = 2'd0;
   localparam logic [1:0] EVT_END_MARK  = 2'd1;
   localparam logic [1:0] EVT_END_FULL  = 2'd2;
   localparam logic [1:0] EVT_NACK      = 2'd3;

   // Characters of the markers.
   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_C  = 8'h43;
   localparam logic [7:0] CHAR_K  = 8'h4B;
   localparam logic [7:0] CHAR_N  = 8'h4E;
   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_F  = 8'h46;
   localparam logic [7:0] CHAR_I  = 8'h49;

   // Markers packed with their first character in the lowest byte.
   localparam logic [31:0] ACK_SEQ = {8'h00, CHAR_K, CHAR_C, CHAR_A};
   localparam logic [31:0] NCK_SEQ = {8'h00, CHAR_K, CHAR_C, CHAR_N};
   localparam logic [31:0] END_SEQ = {CHAR_N, CHAR_I, CHAR_F, CHAR_AT};
   localparam logic [2:0]  START_LEN = 3'd3;
   localparam logic [2:0]  END_LEN   = 3'd4;

   // Length of the start marker kept at the head of every frame.
   localparam int unsigned HEAD_LEN = 3;

   // Advance a sequence match by one byte; a mismatch restarts on the first character.
   function automatic logic [2:0] advance(input logic [2:0] prog, input logic [2:0] len,
                                          input logic [7:0] b, input logic [31:0] seq);
      logic [2:0] result;
      if ((prog < len) && (b == seq[{prog[1:0], 3'b000} +: 8])) begin
         result = prog + 3'd1;
      end else if (b == seq[7:0]) begin
         result = 3'd1;
      end else begin
         result = 3'd0;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/mdfr_ram.sv]
// Generic memory with one write port and one registered read port.
// No dependencies; holds the frame bytes of the receiver.
`timescale 1ns / 1ps
`default_nettype none

module mdfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and read with the data registered; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[rtl/marker_delimited_frame_receiver_top.sv]
// Marker-delimited frame receiver: takes one item per cycle (a received byte, a read of
// the frame store or a rearm), sustaining one item every clock cycle with no stalls of its
// own. A result passes the first result stage, beside the registered read of the frame store
// memory, and then the output register. The input stays ready while a result waits, until
// both result stages are full. The store needs no clearing after reset; the three
// start-marker bytes at its head are held in registers.
// Depends on mdfr_pkg.sv, mdfr_ram.sv and marker_delimited_frame_receiver_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "marker_delimited_frame_receiver_top_assert.svh"

module marker_delimited_frame_receiver_top #(
   parameter int STORE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] read_index
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [7:0] data_byte, [16:8] frame_length, rest zero
   output logic      [1:0]  rsp_tuser    // [1:0] event_kind
);

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int AW = $clog2(STORE_DEPTH);

   typedef enum logic [1:0] {
      MODE_HUNT = 2'd0,
      MODE_FILL = 2'd1,
      MODE_HALT = 2'd2
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [1:0]    ack_prog_ff, ack_prog_in;
   logic [1:0]    nck_prog_ff, nck_prog_in;
   logic [2:0]    end_prog_ff, end_prog_in;
   logic [CW-1:0] count_ff, count_in;
   logic          head_nck_ff, head_nck_in;

   // First result stage, beside the memory read.
   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_kind_ff, s1_kind_in;
   logic [8:0]    s1_len_ff, s1_len_in;
   logic [7:0]    s1_data_ff, s1_data_in;
   logic          s1_use_ram_ff, s1_use_ram_in;

   // Output register.
   logic          s2_valid_ff;
   logic [1:0]    s2_kind_ff;
   logic [8:0]    s2_len_ff;
   logic [7:0]    s2_data_ff;

   logic          accept;
   logic          s1_move;
   logic [1:0]    op;
   logic [7:0]    rx_byte;
   logic [7:0]    read_index;
   logic          ram_we;
   logic          ram_re;
   logic [7:0]    ram_rdata;
   logic [2:0]    ack_adv, nck_adv, end_adv;
   logic          store_full;
   logic          idx_in_range;

   assign op         = req_tuser;
   assign rx_byte    = req_tdata[7:0];
   assign read_index = req_tdata[15:8];

   // Two-stage result pipeline; the input waits only when both stages are held.
   assign s1_move    = !s2_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   assign ack_adv      = mdfr_pkg::advance({1'b0, ack_prog_ff}, mdfr_pkg::START_LEN,
                                           rx_byte, mdfr_pkg::ACK_SEQ);
   assign nck_adv      = mdfr_pkg::advance({1'b0, nck_prog_ff}, mdfr_pkg::START_LEN,
                                           rx_byte, mdfr_pkg::NCK_SEQ);
   assign end_adv      = mdfr_pkg::advance(end_prog_ff, mdfr_pkg::END_LEN,
                                           rx_byte, mdfr_pkg::END_SEQ);
   assign store_full   = count_ff >= CW'(STORE_DEPTH);
   assign idx_in_range = 32'(read_index) < 32'(STORE_DEPTH);

   // Next state and result for the item at the port.
   always_comb begin
      mode_in       = mode_ff;
      ack_prog_in   = ack_prog_ff;
      nck_prog_in   = nck_prog_ff;
      end_prog_in   = end_prog_ff;
      count_in      = count_ff;
      head_nck_in   = head_nck_ff;
      s1_valid_in   = 1'b0;
      s1_kind_in    = mdfr_pkg::EVT_READ_DATA;
      s1_data_in    = 8'd0;
      s1_use_ram_in = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (accept) begin
         case (op)
            mdfr_pkg::OP_READ: begin
               s1_valid_in = 1'b1;
               if (!idx_in_range) begin
                  s1_data_in = 8'd0;
               end else if (read_index == 8'd0) begin
                  s1_data_in = head_nck_ff ? mdfr_pkg::CHAR_N : mdfr_pkg::CHAR_A;
               end else if (read_index == 8'd1) begin
                  s1_data_in = mdfr_pkg::CHAR_C;
               end else if (read_index == 8'd2) begin
                  s1_data_in = mdfr_pkg::CHAR_K;
               end else begin
                  s1_use_ram_in = 1'b1;
                  ram_re        = 1'b1;
               end
            end
            mdfr_pkg::OP_REARM: begin
               mode_in     = MODE_HUNT;
               ack_prog_in = 2'd0;
               nck_prog_in = 2'd0;
               end_prog_in = 3'd0;
            end
            mdfr_pkg::OP_RX_BYTE: begin
               case (mode_ff)
                  MODE_HUNT: begin
                     count_in    = '0;
                     ack_prog_in = ack_adv[1:0];
                     nck_prog_in = nck_adv[1:0];
                     if (ack_adv == mdfr_pkg::START_LEN) begin
                        head_nck_in = 1'b0;
                        count_in    = CW'(mdfr_pkg::HEAD_LEN);
                        ack_prog_in = 2'd0;
                        nck_prog_in = 2'd0;
                        end_prog_in = 3'd0;
                        mode_in     = MODE_FILL;
                     end else if (nck_adv == mdfr_pkg::START_LEN) begin
                        head_nck_in = 1'b1;
                        count_in    = CW'(mdfr_pkg::HEAD_LEN);
                        ack_prog_in = 2'd0;
                        nck_prog_in = 2'd0;
                        mode_in     = MODE_HALT;
                        s1_valid_in = 1'b1;
                        s1_kind_in  = mdfr_pkg::EVT_NACK;
                     end
                  end
                  MODE_FILL: begin
                     end_prog_in = end_adv;
                     if (end_adv == mdfr_pkg::END_LEN || store_full) begin
                        s1_kind_in = mdfr_pkg::EVT_END_FULL;
                        if (end_adv == mdfr_pkg::END_LEN) begin
                           s1_kind_in = mdfr_pkg::EVT_END_MARK;
                           count_in   = (count_ff >= CW'(mdfr_pkg::HEAD_LEN)) ?
                                        count_ff - CW'(mdfr_pkg::HEAD_LEN) : '0;
                        end
                        end_prog_in = 3'd0;
                        mode_in     = MODE_HALT;
                        s1_valid_in = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_len_in = 9'(count_in);

   // Frame bytes past the start marker.
   mdfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(count_ff)),
      .wdata (rx_byte),
      .re    (ram_re),
      .raddr (AW'(read_index)),
      .rdata (ram_rdata)
   );

   // State and both result stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HUNT;
         ack_prog_ff <= 2'd0;
         nck_prog_ff <= 2'd0;
         end_prog_ff <= 3'd0;
         count_ff    <= '0;
         head_nck_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         ack_prog_ff <= ack_prog_in;
         nck_prog_ff <= nck_prog_in;
         end_prog_ff <= end_prog_in;
         count_ff    <= count_in;
         head_nck_ff <= head_nck_in;
         if (s1_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (req_tready) begin
            s1_valid_ff <= s1_valid_in;
         end
      end
      if (s1_move) begin
         s2_kind_ff <= s1_kind_ff;
         s2_len_ff  <= s1_len_ff;
         s2_data_ff <= s1_use_ram_ff ? ram_rdata : s1_data_ff;
      end
      if (req_tready) begin
         s1_kind_ff    <= s1_kind_in;
         s1_len_ff     <= s1_len_in;
         s1_data_ff    <= s1_data_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tuser  = s2_kind_ff;
   assign rsp_tdata  = {7'd0, s2_len_ff, s2_data_ff};

   // Checks on the frame counter, the modes and the result pipeline.
   `MDFR_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STORE_DEPTH), "byte count past store depth")
   `MDFR_ASSERT_ALWAYS(a_fill_has_head, (mode_ff != MODE_FILL) || (count_ff >= CW'(3)), "filling without head")
   `MDFR_ASSERT_ALWAYS(a_hunt_no_end, (mode_ff != MODE_HUNT) || (end_prog_ff == 3'd0), "end match while hunting")
   `MDFR_ASSERT_SAME(a_write_in_fill, ram_we, (mode_ff == MODE_FILL) && !store_full, "store write outside fill")
   `MDFR_ASSERT_NEXT(a_s1_held, s1_valid_ff && s2_valid_ff && !rsp_tready, s1_valid_ff, "held result dropped")

endmodule

`default_nettype wire

[test/marker_delimited_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the marker-delimited frame receiver: table-driven directed items,
// then random frames, rejects, reads and noise, with every result checked against a predictor.
// Depends on mdfr_pkg.sv and marker_delimited_frame_receiver_top.sv.

module marker_delimited_frame_receiver_top_tb;

   localparam int STORE_DEPTH = 256;
   localparam int ITEM_TARGET = 1775;
   localparam int HOLD_AT = 700;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One result: event kind, returned byte and frame length.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [8:0] len;
   } frame_event_type;

   typedef enum logic [1:0] {RCV_HUNT, RCV_FILL, RCV_HALT} rcv_state_type;
   typedef enum {MK_ACK, MK_NCK, MK_FIN} marker_type;

   // One row of the directed table; typed rows carry their own expectation.
   typedef struct {
      logic [1:0]      op;
      logic [7:0]      rx;
      logic [7:0]      idx;
      bit              typed;
      bit              fires;
      frame_event_type ev;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] rx_byte, [15:8] read_index
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] data_byte, [16:8] frame_length, rest zero
   logic [1:0]  rsp_tuser;        // [1:0] event_kind
   logic        hold_off = 1'b0;

   // Predictor state.
   rcv_state_type rx_state = RCV_HUNT;
   int            ack_seen = 0;
   int            nck_seen = 0;
   int            fin_seen = 0;
   int            frame_bytes = 0;
   int            store_filled = 0;
   logic [7:0]    store_image [STORE_DEPTH];

   frame_event_type pending_events [$];
   stim_row_type    directed_rows [$];

   int error_count = 0;
   int work_items = 0;
   int ignored_items = 0;
   int results_seen = 0;
   int held_stalls = 0;
   int kind_seen [4] = '{0, 0, 0, 0};
   int burst_left = 0;

   marker_delimited_frame_receiver_top #(.STORE_DEPTH(STORE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Errors are counted; only the first ten are printed.
   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   function automatic logic [7:0] rand8();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      return v;
   endfunction

   // Characters of the three markers, first character at position zero.
   function automatic logic [7:0] marker_char(input marker_type m, input int pos);
      logic [7:0] c;
      case (m)
         MK_ACK:  c = (pos == 0) ? mdfr_pkg::CHAR_A :
                      (pos == 1) ? mdfr_pkg::CHAR_C : mdfr_pkg::CHAR_K;
         MK_NCK:  c = (pos == 0) ? mdfr_pkg::CHAR_N :
                      (pos == 1) ? mdfr_pkg::CHAR_C : mdfr_pkg::CHAR_K;
         default: c = (pos == 0) ? mdfr_pkg::CHAR_AT :
                      (pos == 1) ? mdfr_pkg::CHAR_F :
                      (pos == 2) ? mdfr_pkg::CHAR_I : mdfr_pkg::CHAR_N;
      endcase
      return c;
   endfunction

   function automatic int marker_len(input marker_type m);
      return (m == MK_FIN) ? 4 : 3;
   endfunction

   // Sequence match: extend on the next character, else restart on the first one.
   function automatic int follow_marker(input marker_type m, input int seen, input logic [7:0] b);
      if (seen < marker_len(m) && b == marker_char(m, seen)) begin
         return seen + 1;
      end
      return (b == marker_char(m, 0)) ? 1 : 0;
   endfunction

   // A start marker found while hunting becomes the head of the frame store.
   function automatic void load_head(input marker_type m);
      for (int p = 0; p < 3; p++) begin
         store_image[p] = marker_char(m, p);
      end
      frame_bytes = 3;
      if (store_filled < 3) begin
         store_filled = 3;
      end
   endfunction

   // Advance the predicted receiver by one item; returns 1 when a result is due.
   function automatic bit predict_event(input logic [1:0] op, input logic [7:0] rx,
                                        input logic [7:0] idx, output frame_event_type ev);
      bit fires;
      fires = 1'b0;
      ev = '0;
      case (op)
         mdfr_pkg::OP_READ: begin
            ev.kind = mdfr_pkg::EVT_READ_DATA;
            ev.data = store_image[idx];
            ev.len = frame_bytes[8:0];
            fires = 1'b1;
         end
         mdfr_pkg::OP_REARM: begin
            rx_state = RCV_HUNT;
            ack_seen = 0;
            nck_seen = 0;
            fin_seen = 0;
         end
         mdfr_pkg::OP_RX_BYTE: begin
            if (rx_state == RCV_HUNT) begin
               frame_bytes = 0;
               ack_seen = follow_marker(MK_ACK, ack_seen, rx);
               nck_seen = follow_marker(MK_NCK, nck_seen, rx);
               if (ack_seen == 3) begin
                  load_head(MK_ACK);
                  ack_seen = 0;
                  nck_seen = 0;
                  fin_seen = 0;
                  rx_state = RCV_FILL;
               end else if (nck_seen == 3) begin
                  load_head(MK_NCK);
                  ack_seen = 0;
                  nck_seen = 0;
                  rx_state = RCV_HALT;
                  ev.kind = mdfr_pkg::EVT_NACK;
                  ev.len = frame_bytes[8:0];
                  fires = 1'b1;
               end
            end else if (rx_state == RCV_FILL) begin
               fin_seen = follow_marker(MK_FIN, fin_seen, rx);
               if (fin_seen == 4 || frame_bytes >= STORE_DEPTH) begin
                  // The end marker wins over a full store; its first three bytes are dropped.
                  ev.kind = mdfr_pkg::EVT_END_FULL;
                  if (fin_seen == 4) begin
                     ev.kind = mdfr_pkg::EVT_END_MARK;
                     frame_bytes = (frame_bytes >= 3) ? frame_bytes - 3 : 0;
                  end
                  fin_seen = 0;
                  rx_state = RCV_HALT;
                  ev.len = frame_bytes[8:0];
                  fires = 1'b1;
               end else begin
                  store_image[frame_bytes] = rx;
                  frame_bytes++;
                  if (frame_bytes > store_filled) begin
                     store_filled = frame_bytes;
                  end
               end
            end
         end
         default: ;
      endcase
      return fires;
   endfunction

   // Present one item in bursts with random gaps and wait until it is taken.
   task automatic offer_item(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] idx);
      int gap;
      bit steady;
      steady = ((work_items / 150) % 4) == 2;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {idx, rx};
      do @(posedge clock); while (!req_tready);
      if (op == OP_UNUSED || (op == mdfr_pkg::OP_RX_BYTE && rx_state == RCV_HALT)) begin
         ignored_items++;
      end else begin
         work_items++;
      end
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] idx);
      frame_event_type ev;
      offer_item(op, rx, idx);
      if (predict_event(op, rx, idx, ev)) begin
         pending_events.push_back(ev);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(mdfr_pkg::OP_RX_BYTE, b, rand8());
   endtask

   task automatic send_marker(input marker_type m);
      for (int p = 0; p < marker_len(m); p++) begin
         send_byte(marker_char(m, p));
      end
   endtask

   // Reads only touch entries already written; half of them aim at the top of the store.
   task automatic send_read();
      int span;
      logic [7:0] idx;
      if (store_filled == 0) begin
         send_item(mdfr_pkg::OP_REARM, rand8(), rand8());
         return;
      end
      if ($urandom_range(0, 1) == 1) begin
         idx = 8'($urandom_range(0, store_filled - 1));
      end else begin
         span = (store_filled > 4) ? 4 : store_filled;
         idx = 8'(store_filled - 1 - int'($urandom_range(0, span - 1)));
      end
      send_item(mdfr_pkg::OP_READ, rand8(), idx);
   endtask

   // Payload byte leaning toward marker characters so partial matches occur often.
   function automatic logic [7:0] frame_char();
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0:       c = mdfr_pkg::CHAR_AT;
         1:       c = mdfr_pkg::CHAR_F;
         2:       c = mdfr_pkg::CHAR_I;
         3:       c = mdfr_pkg::CHAR_N;
         4:       c = mdfr_pkg::CHAR_A;
         5:       c = mdfr_pkg::CHAR_K;
         default: c = rand8();
      endcase
      return c;
   endfunction

   // Payload byte that cannot start an end marker.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = rand8();
      if (c == mdfr_pkg::CHAR_AT) begin
         c = ~c;
      end
      return c;
   endfunction

   // A frame opened by ACK. Shape 0 is a short frame, 1 overflows the store, and 2 has its
   // end marker complete on the byte that also finds the store full.
   task automatic run_frame(input int shape);
      int count;
      int r;
      if (rx_state != RCV_HUNT || $urandom_range(0, 3) == 0) begin
         send_item(mdfr_pkg::OP_REARM, rand8(), rand8());
      end
      repeat ($urandom_range(0, 3)) send_byte(frame_char());
      if ($urandom_range(0, 3) == 0) begin
         send_byte(mdfr_pkg::CHAR_A);
         send_byte(mdfr_pkg::CHAR_C);
         send_byte(frame_char());
      end
      send_marker(MK_ACK);
      case (shape)
         0: begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
            repeat (count) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_read();
               end else begin
                  send_byte(frame_char());
               end
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
               send_marker(MK_FIN);
            end else if (r == 7) begin
               send_byte(mdfr_pkg::CHAR_AT);
               send_byte(mdfr_pkg::CHAR_F);
               send_byte(mdfr_pkg::CHAR_I);
               send_byte(frame_char());
               send_marker(MK_FIN);
            end
         end
         1: begin
            repeat (STORE_DEPTH - 3) send_byte(plain_char());
            repeat ($urandom_range(1, 3)) send_byte(frame_char());
         end
         default: begin
            repeat (STORE_DEPTH - 6) send_byte(plain_char());
            send_marker(MK_FIN);
         end
      endcase
      // Bytes after the end are dropped while halted.
      if (rx_state == RCV_HALT) begin
         repeat ($urandom_range(0, 3)) send_byte(frame_char());
      end
      repeat ($urandom_range(0, 3)) send_read();
   endtask

   task automatic add_row(input logic [1:0] op, input logic [7:0] rx, input logic [7:0] idx,
                          input bit typed, input bit fires, input logic [1:0] kind,
                          input logic [7:0] data, input logic [8:0] len);
      stim_row_type row;
      row.op = op;
      row.rx = rx;
      row.idx = idx;
      row.typed = typed;
      row.fires = fires;
      row.ev.kind = kind;
      row.ev.data = data;
      row.ev.len = len;
      directed_rows.push_back(row);
   endtask

   // Main stimulus: reset, directed table, random mix, drain and verdict.
   initial begin : stimulus
      frame_event_type ev;
      bit fires;
      int scen;
      int r;
      int drain;

      // Unused op after reset and every opcode value, then a reject and a read of its head.
      add_row(OP_UNUSED, 8'hFF, 8'hFF, 1, 0, mdfr_pkg::EVT_READ_DATA, 8'h00, 9'd0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_N, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_C, 8'hFF, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_K, 8'h00, 1, 1, mdfr_pkg::EVT_NACK,
              8'h00, 9'd3);
      add_row(mdfr_pkg::OP_READ, 8'hFF, 8'd0, 1, 1, mdfr_pkg::EVT_READ_DATA,
              mdfr_pkg::CHAR_N, 9'd3);
      // Halted bytes are dropped until a rearm.
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_A, 8'h00, 1, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_REARM, 8'hFF, 8'hFF, 1, 0, '0, '0, '0);
      // Doubled first characters restart each match; extremes of the byte go into the store.
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_A, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_A, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_C, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_K, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, 8'hFF, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, 8'h00, 8'hFF, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_AT, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_AT, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_F, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_I, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_N, 8'h00, 1, 1, mdfr_pkg::EVT_END_MARK,
              8'h00, 9'd6);
      add_row(mdfr_pkg::OP_READ, 8'h00, 8'd3, 1, 1, mdfr_pkg::EVT_READ_DATA, 8'hFF, 9'd6);
      // A rearm keeps the length until the next hunting byte.
      add_row(mdfr_pkg::OP_REARM, 8'h00, 8'h00, 1, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_READ, 8'h00, 8'd4, 1, 1, mdfr_pkg::EVT_READ_DATA, 8'h00, 9'd6);
      // "NACK": the A breaks the reject marker and starts an accept marker.
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_N, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_A, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_C, 8'h00, 0, 0, '0, '0, '0);
      add_row(mdfr_pkg::OP_RX_BYTE, mdfr_pkg::CHAR_K, 8'h00, 0, 0, '0, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < directed_rows.size(); i++) begin
         offer_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].idx);
         fires = predict_event(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].idx, ev);
         if (directed_rows[i].typed) begin
            fires = directed_rows[i].fires;
            ev = directed_rows[i].ev;
         end
         if (fires) begin
            pending_events.push_back(ev);
         end
      end

      // Random part: mostly well-formed frames, with rejects, reads and noise between them.
      scen = 0;
      while (work_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (scen == 4) begin
            run_frame(1);
         end else if (scen == 12) begin
            run_frame(2);
         end else if (r < 2) begin
            run_frame($urandom_range(1, 2));
         end else if (r < 47) begin
            run_frame(0);
         end else if (r < 60) begin
            send_item(mdfr_pkg::OP_REARM, rand8(), rand8());
            if ($urandom_range(0, 1) == 1) begin
               send_byte(mdfr_pkg::CHAR_N);
            end
            send_marker(MK_NCK);
            repeat ($urandom_range(0, 2)) send_read();
         end else if (r < 75) begin
            repeat ($urandom_range(1, 6)) send_read();
         end else begin
            repeat ($urandom_range(3, 10)) begin
               r = $urandom_range(0, 3);
               if (r == int'(mdfr_pkg::OP_READ)) begin
                  send_read();
               end else begin
                  send_item(r[1:0], frame_char(), rand8());
               end
            end
         end
         scen++;
      end
      req_tvalid <= 1'b0;

      // Let every expected result arrive, then watch a little longer for strays.
      drain = 0;
      while (pending_events.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (16) @(posedge clock);
      if (pending_events.size() != 0) begin
         report_error($sformatf("%0d expected results never arrived", pending_events.size()));
      end

      $display({"Run covered %0d items (%0d dropped by the block) and %0d results:",
                " %0d reads, %0d marker ends, %0d full ends, %0d rejects."},
               work_items + ignored_items, ignored_items, results_seen,
               kind_seen[mdfr_pkg::EVT_READ_DATA], kind_seen[mdfr_pkg::EVT_END_MARK],
               kind_seen[mdfr_pkg::EVT_END_FULL], kind_seen[mdfr_pkg::EVT_NACK]);
      $display({"Store written up to %0d entries; input held back %0d cycles during the",
                " long result stall; %0d errors."},
               store_filled, held_stalls, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side stalls on a pattern that changes style at a regular interval.
   initial begin : rsp_side
      int unsigned cyc;
      int unsigned style;
      bit ready;
      cyc = 0;
      style = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 150 == 0) begin
            style = $urandom_range(0, 3);
         end
         case (style)
            0:       ready = 1'b1;
            1:       ready = ($urandom_range(0, 9) < 7);
            2:       ready = (cyc % 3 != 0);
            default: ready = ($urandom_range(0, 9) < 3);
         endcase
         rsp_tready <= ready && !hold_off;
      end
   end

   // One long hold-off of the result side mid-run, so results back up into the input.
   initial begin : long_hold
      int held;
      @(posedge clock);
      while (work_items < HOLD_AT) @(posedge clock);
      hold_off <= 1'b1;
      held = 0;
      while (held < HOLD_CYCLES) begin
         @(posedge clock);
         held++;
      end
      hold_off <= 1'b0;
   end

   // Compare each result taken with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      frame_event_type got;
      frame_event_type want;
      if (!reset) begin
         if (hold_off && req_tvalid && !req_tready) begin
            held_stalls++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.data = rsp_tdata[7:0];
            got.len = rsp_tdata[16:8];
            results_seen++;
            kind_seen[got.kind]++;
            if (pending_events.size() == 0) begin
               report_error($sformatf("unexpected result: kind %0d data %02h length %0d",
                                      got.kind, got.data, got.len));
            end else begin
               want = pending_events.pop_front();
               if (got !== want || rsp_tdata[23:17] !== '0) begin
                  report_error($sformatf({"result mismatch: expected kind %0d data %02h length %0d,",
                                          " got kind %0d data %02h length %0d pad %02h"},
                                         want.kind, want.data, want.len, got.kind, got.data,
                                         got.len, rsp_tdata[23:17]));
               end
            end
         end
      end
   end

   // Hard limit on the whole run.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timeout: %0d results still expected", pending_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[marker_delimited_frame_receiver_top.f]
+incdir+rtl
rtl/mdfr_pkg.sv
rtl/mdfr_ram.sv
rtl/marker_delimited_frame_receiver_top.sv
test/marker_delimited_frame_receiver_top_tb.sv
